// ===== rtl/cartridge_bank_switch_mapper_defines.svh =====
// Shared assertion macros for the bank mapper checker.
`ifndef CARTRIDGE_BANK_SWITCH_MAPPER_DEFINES_SVH
`define CARTRIDGE_BANK_SWITCH_MAPPER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define CBSM_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("cbsm check failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define CBSM_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("cbsm check failed");

`endif

// ===== rtl/cbsm_pkg.sv =====
package cbsm_pkg;

	localparam int CHR_SLOTS = 8;
	localparam int PRG_SLOTS = 4;
	localparam int CHR_ROWS  = CHR_SLOTS / 2;

	localparam logic [1:0] OP_CMD  = 2'd0;
	localparam logic [1:0] OP_DATA = 2'd1;
	localparam logic [1:0] OP_PRG  = 2'd2;
	localparam logic [1:0] OP_CHR  = 2'd3;

	localparam logic REG_PRG_MASK = 1'b0;
	localparam logic REG_CHR_MASK = 1'b1;

	localparam logic [7:0] SEL_MASK  = 8'hC7;
	localparam logic [7:0] EVEN_MASK = 8'hFE;

	localparam logic [7:0] SEL_PAIR0 = 8'h00;
	localparam logic [7:0] SEL_PAIR1 = 8'h01;
	localparam logic [7:0] SEL_PAIR2 = 8'h80;
	localparam logic [7:0] SEL_PAIR3 = 8'h81;
	localparam logic [7:0] SEL_CHR2  = 8'h02;
	localparam logic [7:0] SEL_CHR3  = 8'h03;
	localparam logic [7:0] SEL_CHR4  = 8'h04;
	localparam logic [7:0] SEL_CHR5  = 8'h05;
	localparam logic [7:0] SEL_CHRB2 = 8'h82;
	localparam logic [7:0] SEL_CHRB3 = 8'h83;
	localparam logic [7:0] SEL_CHRB4 = 8'h84;
	localparam logic [7:0] SEL_CHRB5 = 8'h85;
	localparam logic [7:0] SEL_PRG0  = 8'h06;
	localparam logic [7:0] SEL_PRG1  = 8'h07;
	localparam logic [7:0] SEL_PRG2  = 8'h46;
	localparam logic [7:0] SEL_PRG3  = 8'h47;

	localparam logic [7:0] MASK_RESET = 8'hFF;

	typedef struct packed {
		logic [1:0]  chr_we;
		logic [1:0]  chr_row;
		logic [15:0] chr_wdata;
		logic        prg_we;
		logic [1:0]  prg_slot;
		logic [7:0]  prg_wdata;
	} cbsm_wr_t;

	function automatic logic [7:0] prg_reset_bank(input logic [1:0] slot);
		logic [7:0] v;
		unique case (slot)
			2'd0: v = 8'h00;
			2'd1: v = 8'h01;
			2'd2: v = 8'hFE;
			2'd3: v = 8'hFF;
			default: v = 8'h00;
		endcase
		return v;
	endfunction

endpackage

// ===== rtl/cbsm_ram.sv =====
module cbsm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4,
	parameter int LANES = 1
) (
	input  logic                     clk,
	input  logic [LANES-1:0]         we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	localparam int LW = WIDTH / LANES;

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		for (int l = 0; l < LANES; l++) begin
			if (we[l]) begin
				mem[waddr][l*LW +: LW] <= wdata[l*LW +: LW];
			end
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// ===== rtl/cbsm_decode.sv =====
module cbsm_decode (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_we,
	input  logic              data_we,
	input  logic [7:0]        data_byte,
	output cbsm_pkg::cbsm_wr_t wr
);
	import cbsm_pkg::*;

	logic [7:0] command_q;
	logic [7:0] sel;
	logic [2:0] idx;
	logic [2:0] slot_b;
	logic [7:0] even;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			command_q <= 8'h00;
		end else if (cmd_we) begin
			command_q <= data_byte;
		end
	end

	assign sel    = command_q & SEL_MASK;
	assign idx    = command_q[2:0];
	assign slot_b = idx - 3'd2;
	assign even   = data_byte & EVEN_MASK;

	always_comb begin
		wr           = '0;
		wr.chr_wdata = {data_byte, data_byte};
		wr.prg_wdata = data_byte;
		wr.prg_slot  = {sel[6], sel[0]};
		unique case (sel)
			SEL_PAIR0, SEL_PAIR1, SEL_PAIR2, SEL_PAIR3: begin
				wr.chr_we    = 2'b11;
				wr.chr_row   = {sel[7], sel[0]};
				wr.chr_wdata = {even | 8'h01, even};
			end
			SEL_CHR2, SEL_CHR3, SEL_CHR4, SEL_CHR5: begin
				wr.chr_row = idx[2:1];
				wr.chr_we  = idx[0] ? 2'b10 : 2'b01;
			end
			SEL_CHRB2, SEL_CHRB3, SEL_CHRB4, SEL_CHRB5: begin
				wr.chr_row = slot_b[2:1];
				wr.chr_we  = slot_b[0] ? 2'b10 : 2'b01;
			end
			SEL_PRG0, SEL_PRG1, SEL_PRG2, SEL_PRG3: begin
				wr.prg_we = 1'b1;
			end
			default: begin
			end
		endcase
		if (!data_we) begin
			wr.chr_we = 2'b00;
			wr.prg_we = 1'b0;
		end
	end
endmodule

// ===== rtl/cartridge_bank_switch_mapper.sv =====
// Bank-switching address mapper.
// Input stream s_*: s_tuser is the opcode (write command, write bank data,
// translate program offset, translate pattern address); s_tdata carries the
// data byte and the 15-bit offset. Only translate requests produce a result.
// Output stream m_*: m_tdata is the 21-bit ROM byte address, m_tuser is set
// for pattern ROM, clear for program ROM.
// APB port: register 0 (addr 0) program bank mask, register 1 (addr 4)
// pattern bank mask; write only while the stream is idle.
// A translate request passes the read stage and then the output register to m_*.
// Throughput: one request per cycle while no result waits on m_tready, set
// by the single read port of each bank memory; writes land at the accept
// edge, so a translate right after a bank write already sees the new bank.
// Reset: command byte cleared, masks 0xFF, program banks 0,1,0xFE,0xFF, pattern
// banks 0; per-entry valid bits supply these values, no clearing pass.
// Stall: a result waits in the output register; one more translate request is
// taken into the read stage, then s_tready drops until m_tready returns.
module cartridge_bank_switch_mapper (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // [7:0] data_byte, [22:8] offset, [23] zero
	input  logic [1:0]  s_tuser,   // [1:0] opcode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [20:0] rom_address, [23:21] zero
	output logic        m_tuser,   // [0] is_pattern
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import cbsm_pkg::*;

	logic        accept;
	logic [1:0]  op;
	logic [7:0]  data_byte;
	logic [14:0] offset;
	logic        is_xlat;
	logic        out_free;

	cbsm_wr_t    wr;

	logic [7:0]  prg_mask_q;
	logic [7:0]  chr_mask_q;
	logic [PRG_SLOTS-1:0] prg_vld_q;
	logic [CHR_SLOTS-1:0] chr_vld_q;

	logic [7:0]  prg_rdata;
	logic [15:0] chr_rdata;

	logic        vld_s1;
	logic        is_pat_s1;
	logic [14:0] off_s1;
	logic [1:0]  bvld_s1;

	logic        out_vld_q;
	logic [20:0] out_addr_q;
	logic        out_pat_q;

	logic [7:0]  prg_raw;
	logic [7:0]  chr_byte;
	logic [7:0]  chr_raw;
	logic [20:0] next_addr;

	assign op        = s_tuser;
	assign data_byte = s_tdata[7:0];
	assign offset    = s_tdata[22:8];
	assign is_xlat   = (op == OP_PRG) || (op == OP_CHR);

	assign out_free = !out_vld_q || m_tready;
	assign s_tready = !vld_s1 || out_free;
	assign accept   = s_tvalid && s_tready;

	cbsm_decode u_decode (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_we    (accept && (op == OP_CMD)),
		.data_we   (accept && (op == OP_DATA)),
		.data_byte (data_byte),
		.wr        (wr)
	);

	cbsm_ram #(
		.WIDTH (8),
		.DEPTH (PRG_SLOTS),
		.LANES (1)
	) u_prg_ram (
		.clk   (clk),
		.we    (wr.prg_we),
		.waddr (wr.prg_slot),
		.wdata (wr.prg_wdata),
		.re    (accept && is_xlat),
		.raddr (offset[14:13]),
		.rdata (prg_rdata)
	);

	cbsm_ram #(
		.WIDTH (16),
		.DEPTH (CHR_ROWS),
		.LANES (2)
	) u_chr_ram (
		.clk   (clk),
		.we    (wr.chr_we),
		.waddr (wr.chr_row),
		.wdata (wr.chr_wdata),
		.re    (accept && is_xlat),
		.raddr (offset[12:11]),
		.rdata (chr_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prg_vld_q <= '0;
			chr_vld_q <= '0;
		end else begin
			if (wr.prg_we) begin
				prg_vld_q[wr.prg_slot] <= 1'b1;
			end
			if (wr.chr_we[0]) begin
				chr_vld_q[{wr.chr_row, 1'b0}] <= 1'b1;
			end
			if (wr.chr_we[1]) begin
				chr_vld_q[{wr.chr_row, 1'b1}] <= 1'b1;
			end
		end
	end

	// read stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= accept && is_xlat;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && is_xlat) begin
			is_pat_s1 <= (op == OP_CHR);
			off_s1    <= offset;
			bvld_s1   <= (op == OP_CHR) ? chr_vld_q[{offset[12:11], 1'b0} +: 2]
			                            : {1'b0, prg_vld_q[offset[14:13]]};
		end
	end

	assign prg_raw  = bvld_s1[0] ? prg_rdata : prg_reset_bank(off_s1[14:13]);
	assign chr_byte = off_s1[10] ? chr_rdata[15:8] : chr_rdata[7:0];
	assign chr_raw  = bvld_s1[off_s1[10]] ? chr_byte : 8'h00;

	always_comb begin
		if (is_pat_s1) begin
			next_addr = {3'b000, chr_raw & chr_mask_q, off_s1[9:0]};
		end else begin
			next_addr = {prg_raw & prg_mask_q, off_s1[12:0]};
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_free) begin
			out_vld_q <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && vld_s1) begin
			out_addr_q <= next_addr;
			out_pat_q  <= is_pat_s1;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {3'b000, out_addr_q};
	assign m_tuser  = out_pat_q;

	// register port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prg_mask_q <= MASK_RESET;
			chr_mask_q <= MASK_RESET;
		end else if (psel && penable && pwrite && pready) begin
			if (paddr[2] == REG_PRG_MASK) begin
				prg_mask_q <= pwdata[7:0];
			end else begin
				chr_mask_q <= pwdata[7:0];
			end
		end
	end

	assign pready = 1'b1;
	assign prdata = {24'h000000, (paddr[2] == REG_CHR_MASK) ? chr_mask_q : prg_mask_q};
endmodule

// ===== rtl/cbsm_checker.sv =====
`include "cartridge_bank_switch_mapper_defines.svh"

module cbsm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata,
	input logic        m_tuser,
	input logic        psel,
	input logic        pwrite,
	input logic [31:0] prdata,
	input logic        pready
);
	// input side only backs up behind a waiting result
	`CBSM_ASSERT_IMPL(a_stall_cause, !s_tready, m_tvalid && !m_tready)

	// waiting result holds
	`CBSM_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

	// address never exceeds 21 bits
	`CBSM_ASSERT_IMPL(a_addr_width, m_tvalid, m_tdata[23:21] == 3'b000)

	// register reads carry only the 8-bit mask
	`CBSM_ASSERT_IMPL(a_prdata_width, psel && !pwrite, pready && (prdata[31:8] == 24'h000000))
endmodule

bind cartridge_bank_switch_mapper cbsm_checker u_cbsm_checker (.*);
